>>> rtl/sts_pkg.sv
// Shared constants, codes and control types of the sorted table search core.
package sts_pkg;

  localparam int DEPTH      = 1024;
  localparam int WORD_BITS  = 32;
  localparam int DATA_BITS  = 32;
  localparam int RANGE_BITS = 10;
  localparam int MODE_BITS  = 2;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  // Signed cursor width: holds any range index, DEPTH itself and minus one.
  localparam int CUR_BITS   = ((ADDR_BITS > RANGE_BITS) ? ADDR_BITS : RANGE_BITS) + 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD = 2'd0,
    MODE_BIN  = 2'd1,
    MODE_LIN  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_BIN_PROBE = 7'b0000100,
    S_BIN_CMP   = 7'b0001000,
    S_LIN_PROBE = 7'b0010000,
    S_LIN_CMP   = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_wr;
    logic capture;
    logic probe_bin;
    logic probe_lin;
    logic cmp_bin;
    logic cmp_lin;
    logic out_load;
  } sts_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic range_ok;
    logic hit;
    logic out_free;
  } sts_stat_t;

  // Sign-extend the input word, then keep it in WORD_BITS bits.
  function automatic logic signed [WORD_BITS-1:0] key_from_input(
      input logic signed [DATA_BITS-1:0] raw);
    logic signed [63:0] ext;
    ext = 64'(raw);
    return ext[WORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/sts_ctrl.sv
// Controller state machine of the sorted table search core.
module sts_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [sts_pkg::MODE_BITS-1:0]     in_mode,
  output logic                              in_ready,
  input  sts_pkg::sts_stat_t                stat,
  output sts_pkg::sts_cmd_t                 cmd
);

  sts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sts_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sts_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_nxt = sts_pkg::S_IDLE;
      end
      sts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (in_mode == sts_pkg::MODE_LOAD) begin
            cmd.load_wr = 1'b1;
          end else if (in_mode == sts_pkg::MODE_BIN) begin
            cmd.capture = 1'b1;
            state_nxt   = sts_pkg::S_BIN_PROBE;
          end else if (in_mode == sts_pkg::MODE_LIN) begin
            cmd.capture = 1'b1;
            state_nxt   = sts_pkg::S_LIN_PROBE;
          end else begin
            state_nxt = sts_pkg::S_IDLE;
          end
        end
      end
      sts_pkg::S_BIN_PROBE: begin
        if (stat.range_ok) begin
          cmd.probe_bin = 1'b1;
          state_nxt     = sts_pkg::S_BIN_CMP;
        end else begin
          state_nxt = sts_pkg::S_DONE;
        end
      end
      sts_pkg::S_BIN_CMP: begin
        cmd.cmp_bin = 1'b1;
        state_nxt   = stat.hit ? sts_pkg::S_DONE : sts_pkg::S_BIN_PROBE;
      end
      sts_pkg::S_LIN_PROBE: begin
        if (stat.range_ok) begin
          cmd.probe_lin = 1'b1;
          state_nxt     = sts_pkg::S_LIN_CMP;
        end else begin
          state_nxt = sts_pkg::S_DONE;
        end
      end
      sts_pkg::S_LIN_CMP: begin
        cmd.cmp_lin = 1'b1;
        state_nxt   = stat.hit ? sts_pkg::S_DONE : sts_pkg::S_LIN_PROBE;
      end
      sts_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sts_datapath.sv
// Datapath of the sorted table search core: entry memory, cursors, compare, result register.
module sts_datapath (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic signed [sts_pkg::DATA_BITS-1:0]     in_data_value,
  input  logic [sts_pkg::RANGE_BITS-1:0]           in_range_low,
  input  logic [sts_pkg::RANGE_BITS-1:0]           in_range_high,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic                                     out_found,
  input  sts_pkg::sts_cmd_t                        cmd,
  output sts_pkg::sts_stat_t                       stat
);

  localparam int AW = sts_pkg::ADDR_BITS;
  localparam int CW = sts_pkg::CUR_BITS;
  localparam int WB = sts_pkg::WORD_BITS;
  localparam logic signed [CW-1:0] LAST_IDX = CW'(sts_pkg::DEPTH - 1);
  localparam logic signed [CW-1:0] ONE      = CW'(1);

  logic [WB-1:0]          mem [sts_pkg::DEPTH];
  logic signed [WB-1:0]   rdata_r;
  logic signed [WB-1:0]   key_r;
  logic signed [CW-1:0]   lo_r, hi_r, mid_r;
  logic [AW-1:0]          clr_cnt_r;
  logic                   found_r;
  logic                   out_valid_r, out_found_r;

  logic signed [CW-1:0]   in_lo, in_hi, mid;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [WB-1:0]          wr_data;
  logic signed [WB-1:0]   in_key;

  assign in_key = sts_pkg::key_from_input(in_data_value);
  assign in_lo  = CW'(in_range_low);
  assign in_hi  = CW'(in_range_high);
  assign mid    = lo_r + ((hi_r - lo_r) >>> 1);

  // Clear sweep writes zero; a load past the table is dropped.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (cmd.load_wr && (in_lo <= LAST_IDX)) begin
      wr_en   = 1'b1;
      wr_addr = in_lo[AW-1:0];
      wr_data = in_key;
    end
  end

  assign rd_en   = cmd.probe_bin | cmd.probe_lin;
  assign rd_addr = cmd.probe_bin ? mid[AW-1:0] : lo_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r   <= in_key;
      lo_r    <= in_lo;
      hi_r    <= (in_hi > LAST_IDX) ? LAST_IDX : in_hi;
      found_r <= 1'b0;
    end else begin
      if (cmd.probe_bin) mid_r <= mid;
      if (cmd.cmp_bin) begin
        priority if (key_r == rdata_r) begin
          found_r <= 1'b1;
        end else if (key_r > rdata_r) begin
          lo_r <= mid_r + ONE;
        end else begin
          hi_r <= mid_r - ONE;
        end
      end
      if (cmd.cmp_lin) begin
        if (key_r == rdata_r) begin
          found_r <= 1'b1;
        end else begin
          lo_r <= lo_r + ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_found_r <= found_r;
  end

  assign stat.clear_last = (clr_cnt_r == AW'(sts_pkg::DEPTH - 1));
  assign stat.range_ok   = (hi_r >= lo_r);
  assign stat.hit        = (key_r == rdata_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

>>> rtl/sorted_table_search_core.sv
// Top level of the sorted table search core: a 1024-word signed table with binary
// and linear search over an inclusive index range. After reset the core runs a
// clearing pass that writes zero to all DEPTH entries, one per cycle; in_ready
// stays low until it ends. A load writes its entry as it is accepted, and loads
// may follow back to back. A search holds the input side from acceptance until
// its result enters the output register: each probe is one registered read of
// the single-port entry memory followed by one compare, and a result load ends
// the search; a search that misses first makes one more, final range check. The
// result load waits while an earlier result still sits unread in the output
// register. The result register lets the next item be accepted while a finished
// result waits for out_ready. Range high indices past the table are clamped to
// the last entry; a load past the table is dropped, and the unused mode code is
// accepted and dropped without a result.
module sorted_table_search_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sts_pkg::MODE_BITS-1:0]          in_mode,
  input  logic signed [sts_pkg::DATA_BITS-1:0]   in_data_value,
  input  logic [sts_pkg::RANGE_BITS-1:0]         in_range_low,
  input  logic [sts_pkg::RANGE_BITS-1:0]         in_range_high,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_found
);

  sts_pkg::sts_cmd_t  cmd;
  sts_pkg::sts_stat_t stat;

  // Sequence the clear pass, loads and search probes.
  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the table, the search cursors and the result register.
  sts_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_data_value (in_data_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> rtl/sts_checker.sv
// Port-level checker of the sorted table search core and its bind.
module sts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [sts_pkg::MODE_BITS-1:0]     in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_found
);

  // Reset starts the clearing pass: nothing is taken and nothing is offered.
  a_reset_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready straight after reset");

  a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A search keeps the core busy for at least the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready &&
      (in_mode == sts_pkg::MODE_BIN || in_mode == sts_pkg::MODE_LIN) |=> !in_ready)
    else $error("search transfer did not hold the input side");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("stalled result dropped or changed");

endmodule

bind sorted_table_search_core sts_checker u_sts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_found (out_found)
);

>>> dv/tb.sv
// Self-checking testbench for the sorted table search core: loads, binary and linear searches.
module tb;
  import sts_pkg::*;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [MODE_BITS-1:0]          in_mode;
  logic signed [DATA_BITS-1:0]   in_data_value;
  logic [RANGE_BITS-1:0]         in_range_low;
  logic [RANGE_BITS-1:0]         in_range_high;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_found;

  // Shadow copy of the entry table, updated as each load transfer is accepted.
  logic signed [WORD_BITS-1:0]   table_model [DEPTH];
  // Expected found flags, oldest first.
  bit                            found_expect_q [$];

  bit  idle_on;
  int  errors;
  int  items_sent;
  int  out_stall;
  bit  found_exp;

  localparam longint MIN_WORD = -(longint'(1) << 31);
  localparam longint MAX_WORD = (longint'(1) << 31) - 1;

  sorted_table_search_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_data_value (in_data_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Binary search as the core walks it: probe the midpoint, rounding down, and
  // halve the range until a hit or an empty range. Works on unsorted ranges too.
  function automatic bit bin_search_hit(logic signed [WORD_BITS-1:0] key, int lo, int hi);
    int mid;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (key > table_model[mid]) lo = mid + 1;
      else if (key < table_model[mid]) hi = mid - 1;
      else return 1'b1;
    end
    return 1'b0;
  endfunction

  // Upward scan from the low index; stop at the first equal entry.
  function automatic bit lin_scan_hit(logic signed [WORD_BITS-1:0] key, int lo, int hi);
    for (int i = lo; i <= hi; i++) begin
      if (table_model[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted transfer: a load updates the shadow table, a search queues its expected flag.
  function automatic void apply_item(mode_t mode, logic signed [WORD_BITS-1:0] value,
                                     int lo, int hi);
    bit hit;
    hit = 1'b0;
    case (mode)
      MODE_LOAD: begin
        if (lo < DEPTH) table_model[lo] = value;
        items_sent++;
      end
      MODE_BIN, MODE_LIN: begin
        // Clamp the high index to the last entry; an inverted range misses.
        if (hi > DEPTH - 1) hi = DEPTH - 1;
        if (lo <= hi) hit = (mode == MODE_BIN) ? bin_search_hit(value, lo, hi)
                                               : lin_scan_hit(value, lo, hi);
        found_expect_q.push_back(hit);
        items_sent++;
      end
      default: ;  // unused code: dropped by the core, no result
    endcase
  endfunction

  // Drive one item from a falling edge, hold it until the transfer, then
  // predict and return at the next falling edge.
  task automatic send_item(input mode_t mode, input logic signed [DATA_BITS-1:0] value,
                           input int lo, input int hi);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_data_value <= value;
    in_range_low  <= lo[RANGE_BITS-1:0];
    in_range_high <= hi[RANGE_BITS-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(mode, value, lo, hi);
    @(negedge clk);
  endtask

  // Result side: stall in short random bursts while idling is enabled.
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (found_expect_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual found=%0b",
                 $time, out_found);
        errors++;
      end else begin
        found_exp = found_expect_q.pop_front();
        if (out_found !== found_exp) begin
          $display("%0t: found mismatch: expected %0b, actual %0b", $time, found_exp, out_found);
          errors++;
        end
      end
    end
  end

  // One stray item: ignored code, a load anywhere, or a search over a random,
  // often unsorted or inverted range.
  task automatic noise_item();
    int lo;
    int hi;
    lo = $urandom_range(0, DEPTH - 1);
    hi = $urandom_range(0, DEPTH - 1);
    case ($urandom_range(0, 4))
      0: send_item(MODE_NONE, $urandom(), lo, hi);
      1: send_item(MODE_LOAD, $urandom(), lo, hi);
      2: send_item(MODE_BIN, $urandom(), lo, hi);
      3: begin
        // Keep linear scans short: the core reads and compares each entry in turn.
        if ($urandom_range(0, 1) == 0) hi = $urandom_range(0, lo);
        else hi = (lo + $urandom_range(0, 40) > DEPTH - 1) ? DEPTH - 1
                                                            : lo + $urandom_range(0, 40);
        send_item(MODE_LIN, (hi >= lo) ? table_model[hi] : $urandom(), lo, hi);
      end
      default: begin
        lo = $urandom_range(1, DEPTH - 1);
        send_item(MODE_BIN, table_model[lo], lo, $urandom_range(0, lo - 1));
      end
    endcase
  endtask

  // Load an ascending run of random values into a random region, then search it.
  task automatic sorted_run(input int max_len);
    int                          len;
    int                          base_idx;
    int                          step_max;
    int                          k;
    int                          lo;
    int                          hi;
    longint                      span;
    longint                      cur;
    logic signed [WORD_BITS-1:0] run_vals [$];
    logic signed [WORD_BITS-1:0] key;
    len      = ($urandom_range(0, 15) == 0) ? $urandom_range(49, max_len) : $urandom_range(1, 48);
    base_idx = $urandom_range(0, DEPTH - len);
    step_max = 1 << $urandom_range(0, 22);
    span     = (longint'(1) << 32) - longint'(len) * step_max;
    case ($urandom_range(0, 9))
      0:       cur = MIN_WORD;
      1:       cur = MAX_WORD - longint'(len - 1) * step_max;
      default: cur = longint'({$urandom(), $urandom()} % span) + MIN_WORD;
    endcase
    for (int j = 0; j < len; j++) begin
      run_vals.push_back(cur[WORD_BITS-1:0]);
      cur = cur + $urandom_range(0, step_max);
    end
    for (int j = 0; j < len; j++) begin
      send_item(MODE_LOAD, run_vals[j], base_idx + j, $urandom_range(0, DEPTH - 1));
      if ($urandom_range(0, 31) == 0) noise_item();
    end
    repeat ($urandom_range(2, 8)) begin
      k = $urandom_range(0, len - 1);
      // Aim at a stored value or just beside it, so hits and misses both occur.
      key = run_vals[k] + (int'($urandom_range(0, 3)) - 1);
      lo  = base_idx + $urandom_range(0, k);
      hi  = base_idx + k + $urandom_range(0, len - 1 - k);
      case ($urandom_range(0, 5))
        0: send_item(MODE_BIN, key, base_idx, base_idx + len - 1);
        1: send_item(MODE_BIN, key, lo, hi);
        2: send_item(MODE_LIN, key, base_idx, base_idx + len - 1);
        3: send_item(MODE_LIN, key, lo, hi);
        4: send_item(MODE_BIN, key, lo, $urandom_range(lo, DEPTH - 1));
        default: noise_item();
      endcase
    end
  endtask

  // The clearing pass must leave every entry at zero.
  task automatic test_cleared_table();
    send_item(MODE_BIN, 0, 0, DEPTH - 1);
    send_item(MODE_LIN, 0, DEPTH - 1, DEPTH - 1);
    send_item(MODE_BIN, 32'sd5, 0, DEPTH - 1);
    send_item(MODE_LIN, 32'sd1, 0, DEPTH - 1);
  endtask

  // Extreme values and indices, inverted ranges, the unused code and unsorted probes.
  task automatic test_extremes();
    send_item(MODE_LOAD, 32'sh8000_0000, 0, DEPTH - 1);
    send_item(MODE_LOAD, 32'sh7FFF_FFFF, DEPTH - 1, 0);
    send_item(MODE_LOAD, -32'sd1, 511, 0);
    send_item(MODE_LOAD, 32'sd1, 512, DEPTH - 1);
    send_item(MODE_BIN, 32'sh8000_0000, 0, 0);
    send_item(MODE_BIN, 32'sh7FFF_FFFF, DEPTH - 1, DEPTH - 1);
    send_item(MODE_LIN, 32'sh7FFF_FFFF, DEPTH - 1, DEPTH - 1);
    send_item(MODE_LIN, 32'sh8000_0000, 0, DEPTH - 1);
    send_item(MODE_BIN, 32'sh7FFF_FFFF, 0, DEPTH - 1);
    send_item(MODE_BIN, 32'sh8000_0000, 0, DEPTH - 1);
    send_item(MODE_LIN, 0, DEPTH - 1, 0);
    send_item(MODE_BIN, 0, DEPTH - 1, 0);
    send_item(MODE_BIN, 32'sd1, 512, 511);
    send_item(MODE_NONE, -32'sd1, DEPTH - 1, DEPTH - 1);
    send_item(MODE_LIN, 32'sd1, 0, DEPTH - 1);
    send_item(MODE_BIN, 32'sd12345, 0, DEPTH - 1);
    send_item(MODE_LIN, 0, 1000, DEPTH - 1);
  endtask

  // Bulk of the run: sorted regions with searches, idling switched per run.
  task automatic test_sorted_runs();
    while (items_sent < 1550) begin
      idle_on = ($urandom_range(0, 3) != 0);
      sorted_run(300);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) noise_item();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_tail();
    idle_on = 1'b0;
    while (items_sent < 1750) sorted_run(48);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_LOAD;
    in_data_value = '0;
    in_range_low  = '0;
    in_range_high = '0;
    out_ready     = 1'b0;
    out_stall     = 0;
    idle_on       = 1'b1;
    errors        = 0;
    items_sent    = 0;
    for (int i = 0; i < DEPTH; i++) table_model[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_cleared_table();
    test_extremes();
    test_sorted_runs();
    test_steady_tail();

    // Release the input side and drain the outstanding results.
    in_valid <= 1'b0;
    while (found_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && found_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, clearing pass included.
  initial begin
    #120000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
